FILE: rtl/sorted_key_table_defines.svh
// Assertion macros for the sorted key table; clk and rst_n are taken from the using scope.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Same-cycle implication.
`define SKT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int CMD_W  = 2;
  localparam int ID_W   = 24;
  localparam int KEY_W  = 8;
  localparam int ST_W   = 2;
  localparam int SLOT_W = 6;
  localparam int RMV_W  = 7;
  localparam int SPAN_W = 8;
  localparam int HELD_W = 7;
  localparam int CAP_W  = 7;
  localparam int ENT_W  = ID_W + KEY_W;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FLD_W   = SLOT_W + RMV_W + SPAN_W + HELD_W;
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FLD_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } skt_cmd_t;

  typedef enum logic [ST_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } skt_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_SWEEP,
    S_QRY0,
    S_QRY1,
    S_QRY2,
    S_RESP
  } skt_state_t;

  typedef struct packed {
    skt_cmd_t          cmd;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
  } skt_item_t;

  typedef struct packed {
    skt_status_t       status;
    logic [SLOT_W-1:0] slot;
    logic [RMV_W-1:0]  removed;
    logic [SPAN_W-1:0] span;
    logic [HELD_W-1:0] held;
  } skt_res_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_key_table.sv
// Channel | Dir | Ports                | Contents
// in      | in  | in_tvalid/tready     | tuser: cmd; tdata: entry_id, entry_key
// out     | out | out_tvalid/tready    | tuser: status; tdata: slot, removed_count,
//         |     |                      |   key_span, entries_held
// cfg     | in  | cfg_wr_en/wr_data    | capacity_in_use
//
// Insert runs a binary search over the held keys, then moves the entries above the slot
// up one at a time and writes the new entry; delete sweeps every held entry once; query
// reads the first and last entries; full insert, empty query and unused cmd go straight to the response.
// The entry store does one read and one write per cycle. Reset is synchronous; the
// store needs no clearing pass. A finished result waits in the output register while the
// next command runs; a second one holds the engine, and the input, until it drains.
`default_nettype none

`include "sorted_key_table_defines.svh"

module sorted_key_table import skt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_id, entry_key
  input  logic [CMD_W-1:0]       in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slot, removed_count, key_span, entries_held
  output logic [ST_W-1:0]        out_tuser   // status
);

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_eff;
  skt_item_t        item;
  skt_res_t         eng_res;
  logic             eng_idle;
  logic             eng_res_valid;
  logic             res_ready;
  logic             start;
  logic             out_valid_r, out_valid_nxt;
  skt_res_t         out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (int'(cap_r) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign item.cmd = skt_cmd_t'(in_tuser);
  assign item.id  = in_tdata[ID_W-1:0];
  assign item.key = in_tdata[ID_W +: KEY_W];

  assign in_tready = eng_idle;
  assign start     = in_tvalid && in_tready;
  assign res_ready = !out_valid_r || out_tready;

  skt_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .item_i      (item),
    .cap_eff_i   (cap_eff),
    .idle_o      (eng_idle),
    .res_valid_o (eng_res_valid),
    .res_ready_i (res_ready),
    .res_o       (eng_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eng_res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && res_ready) begin
      out_r <= eng_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_r.held, out_r.span, out_r.removed, out_r.slot};

  `SKT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `SKT_ASSERT_SAME(a_empty_has_none, out_valid_r && out_r.status == STAT_EMPTY, out_r.held == '0 && out_r.span == '0, "empty result holds entries")
  `SKT_ASSERT_SAME(a_removed_is_ok, out_valid_r && out_r.removed != '0, out_r.status == STAT_OK, "removal without ok status")

endmodule

`default_nettype wire

FILE: rtl/skt_ram.sv
`default_nettype none

module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/skt_engine.sv
`default_nettype none

module skt_engine import skt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  skt_item_t        item_i,
  input  logic [CNT_W-1:0] cap_eff_i,
  output logic             idle_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output skt_res_t         res_o
);

  skt_state_t       state_r, state_nxt;
  skt_item_t        item_r, item_nxt;
  skt_res_t         res_r, res_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hip1_r, hip1_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] wptr_r, wptr_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [KEY_W-1:0] first_r, first_nxt;
  logic             pend_r, pend_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;

  logic [KEY_W-1:0] rkey;
  logic             key_lt;
  logic             key_gt;
  logic             full;
  logic             range_open;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic             shift_done;
  logic             sweep_done;

  skt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rkey       = ram_rdata[KEY_W-1:0];
  assign key_lt     = rkey < item_r.key;
  assign key_gt     = rkey > item_r.key;
  assign full       = count_r >= cap_eff_i;
  assign range_open = lo_r < hip1_r;
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hip1_r} - (CNT_W+1)'(1);
  assign mid        = mid_sum[IDX_W:1];
  assign shift_done = (ptr_r == CNT_W'(slot_r)) && !pend_r;
  assign sweep_done = (ptr_r == count_r) && !pend_r;

  assign idle_o      = state_r == S_IDLE;
  assign res_valid_o = state_r == S_RESP;
  assign res_o       = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          unique case (item_i.cmd)
            CMD_INSERT: state_nxt = full ? S_RESP : S_PROBE;
            CMD_DELETE: state_nxt = S_SWEEP;
            CMD_QUERY:  state_nxt = (count_r == '0) ? S_RESP : S_QRY0;
            CMD_NOP:    state_nxt = S_RESP;
          endcase
        end
      end
      S_PROBE: state_nxt = range_open ? S_CMP : S_SHIFT;
      S_CMP:   state_nxt = (key_lt || key_gt) ? S_PROBE : S_SHIFT;
      S_SHIFT: state_nxt = shift_done ? S_RESP : S_SHIFT;
      S_SWEEP: state_nxt = sweep_done ? S_RESP : S_SWEEP;
      S_QRY0:  state_nxt = S_QRY1;
      S_QRY1:  state_nxt = S_QRY2;
      S_QRY2:  state_nxt = S_RESP;
      S_RESP:  state_nxt = res_ready_i ? S_IDLE : S_RESP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    item_nxt  = item_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hip1_nxt  = hip1_r;
    ptr_nxt   = ptr_r;
    wptr_nxt  = wptr_r;
    mid_nxt   = mid_r;
    slot_nxt  = slot_r;
    first_nxt = first_r;
    pend_nxt  = pend_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          item_nxt        = item_i;
          lo_nxt          = '0;
          hip1_nxt        = count_r;
          ptr_nxt         = '0;
          wptr_nxt        = '0;
          pend_nxt        = 1'b0;
          res_nxt.status  = STAT_OK;
          res_nxt.slot    = '0;
          res_nxt.removed = '0;
          res_nxt.span    = '0;
          res_nxt.held    = HELD_W'(count_r);
          if (item_i.cmd == CMD_INSERT && full) begin
            res_nxt.status = STAT_FULL;
          end
          if (item_i.cmd == CMD_QUERY && count_r == '0) begin
            res_nxt.status = STAT_EMPTY;
          end
        end
      end
      S_PROBE: begin
        if (range_open) begin
          ram_raddr = mid;
          mid_nxt   = mid;
        end else begin
          slot_nxt = lo_r[IDX_W-1:0];
          ptr_nxt  = count_r;
          pend_nxt = 1'b0;
        end
      end
      S_CMP: begin
        priority if (key_gt) begin
          hip1_nxt = CNT_W'(mid_r);
        end else if (key_lt) begin
          lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
        end else begin
          slot_nxt = mid_r;
          ptr_nxt  = count_r;
          pend_nxt = 1'b0;
        end
      end
      S_SHIFT: begin
        // move one entry up per cycle, read ahead of the write
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(ptr_r + CNT_W'(1));
          ram_wdata = ram_rdata;
        end
        if (ptr_r > CNT_W'(slot_r)) begin
          ram_raddr = IDX_W'(ptr_r - CNT_W'(1));
          ptr_nxt   = ptr_r - CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (shift_done) begin
          ram_we       = 1'b1;
          ram_waddr    = slot_r;
          ram_wdata    = {item_r.id, item_r.key};
          count_nxt    = count_r + CNT_W'(1);
          res_nxt.slot = SLOT_W'(slot_r);
          res_nxt.held = HELD_W'(count_r + CNT_W'(1));
        end
      end
      S_SWEEP: begin
        // compact in place, dropping every matching key
        if (ptr_r < count_r) begin
          ram_raddr = ptr_r[IDX_W-1:0];
          ptr_nxt   = ptr_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (key_lt || key_gt)) begin
          ram_we    = 1'b1;
          ram_waddr = wptr_r[IDX_W-1:0];
          ram_wdata = ram_rdata;
          wptr_nxt  = wptr_r + CNT_W'(1);
        end
        if (sweep_done) begin
          count_nxt       = wptr_r;
          res_nxt.removed = RMV_W'(count_r - wptr_r);
          res_nxt.held    = HELD_W'(wptr_r);
          res_nxt.status  = (count_r == wptr_r) ? STAT_NOTFOUND : STAT_OK;
        end
      end
      S_QRY0: begin
        ram_raddr = '0;
      end
      S_QRY1: begin
        ram_raddr = IDX_W'(count_r - CNT_W'(1));
        first_nxt = rkey;
      end
      S_QRY2: begin
        res_nxt.span = SPAN_W'(rkey - first_r);
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    lo_r    <= lo_nxt;
    hip1_r  <= hip1_nxt;
    ptr_r   <= ptr_nxt;
    wptr_r  <= wptr_nxt;
    mid_r   <= mid_nxt;
    slot_r  <= slot_nxt;
    first_r <= first_nxt;
  end

endmodule

`default_nettype wire
